### design/rspr_pkg.sv
// ----------------------------------------------------------------------------
// rspr_pkg: shared definitions for the recency stack
// Identifier width, request codes, default depth and the control word
// that the top level broadcasts to every cell of the row.
// ----------------------------------------------------------------------------
package rspr_pkg;

	// default number of history cells
	localparam int DEPTH_DEF = 16;

	// identifier width
	localparam int ID_W = 32;

	// request codes
	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// control word broadcast to all cells
	typedef struct packed {
		logic cmp;    // capture the compare against the request identifier
		logic add;    // push the identifier on top, shifting older entries down
		logic rmv;    // delete the matched entry, closing the gap
		logic found;  // one cell holds the identifier
	} cell_ctl_t;

endpackage

### design/rspr_req_if.sv
// ----------------------------------------------------------------------------
// rspr_req_if: request channel
// Valid/ready channel carrying one request word: type and identifier.
// ----------------------------------------------------------------------------
interface rspr_req_if;

	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic [rspr_pkg::ID_W-1:0] window_id;

	modport source (output valid, output req_type, output window_id, input ready);
	modport sink   (input valid, input req_type, input window_id, output ready);

endinterface

### design/rspr_rsp_if.sv
// ----------------------------------------------------------------------------
// rspr_rsp_if: response channel
// Valid/ready channel carrying one response word per request.
// ----------------------------------------------------------------------------
interface rspr_rsp_if #(
	parameter int CNT_W = $clog2(rspr_pkg::DEPTH_DEF + 1)
);

	logic                      valid;
	logic                      ready;
	logic [rspr_pkg::ID_W-1:0] top_window;
	logic [CNT_W-1:0]          entry_count;
	logic                      history_empty;
	logic                      was_present;

	modport source (
		output valid, output top_window, output entry_count,
		output history_empty, output was_present, input ready
	);
	modport sink (
		input valid, input top_window, input entry_count,
		input history_empty, input was_present, output ready
	);

endinterface

### design/rspr_cell.sv
// ----------------------------------------------------------------------------
// rspr_cell: one slot of the recency row
// Holds one identifier, compares it against the request and takes the
// entry of its newer or older neighbor when the row shifts.
// ----------------------------------------------------------------------------
module rspr_cell #(
	parameter int DEPTH = rspr_pkg::DEPTH_DEF,
	parameter int IDX   = 0,
	parameter int IDX_W = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rspr_pkg::cell_ctl_t       ctl,
	input  logic [IDX_W-1:0]          match_idx,
	input  logic [CNT_W-1:0]          count,
	input  logic [rspr_pkg::ID_W-1:0] id,
	input  logic [rspr_pkg::ID_W-1:0] newer,
	input  logic [rspr_pkg::ID_W-1:0] older,
	output logic [rspr_pkg::ID_W-1:0] entry,
	output logic                      hit
);

	localparam logic [CNT_W-1:0] POS_C = CNT_W'(IDX);
	localparam logic [IDX_W-1:0] POS_I = IDX_W'(IDX);

	logic [rspr_pkg::ID_W-1:0] entry_q;
	logic                      hit_q;
	logic                      occupied;
	logic                      take_newer;
	logic                      take_older;

	// slot holds a live entry when it lies below the fill count
	assign occupied = POS_C < count;

	// add shifts every slot down to the matched one, or the whole row on a miss
	assign take_newer = ctl.add && (!ctl.found || (POS_I <= match_idx));
	// remove pulls every slot from the matched one onward up by one
	assign take_older = ctl.rmv && ctl.found && (POS_I >= match_idx);

	// capture the compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.cmp) begin
			hit_q <= occupied && (entry_q == id);
		end
	end

	// advance the entry
	always_ff @(posedge clk) begin
		if (take_newer) begin
			entry_q <= newer;
		end else if (take_older) begin
			entry_q <= older;
		end
	end

	assign entry = entry_q;
	assign hit   = hit_q;

endmodule

### design/recency_stack_promote_remove.sv
// ----------------------------------------------------------------------------
// recency_stack_promote_remove: most-recently-used identifier history
// Row of DEPTH cells, newest in cell 0, with a small sequencer on top.
// ----------------------------------------------------------------------------
// Each request goes through these steps, from acceptance to a response in the
// output register: accept, compare in all cells at once, shift the row, load
// the response. The next request is accepted once the response is loaded,
// even while it still waits for the sink; a stalled response sink adds its
// stall to the load step. The compare-then-shift sequence over the cell row
// handles one request at a time. No identifier is ever held twice, so at most
// one cell matches. The fill count clears at reset; no clearing pass.
// ----------------------------------------------------------------------------
module recency_stack_promote_remove #(
	parameter int DEPTH = rspr_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rspr_req_if.sink    req,
	rspr_rsp_if.source  rsp
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_RSP  = 2'd3;

	logic [1:0]                state_q;
	logic                      req_type_q;
	logic [rspr_pkg::ID_W-1:0] id_q;
	logic [CNT_W-1:0]          count_q;
	logic                      found_q;

	logic                      rsp_valid_q;
	logic [rspr_pkg::ID_W-1:0] top_q;
	logic [CNT_W-1:0]          rsp_count_q;
	logic                      empty_q;
	logic                      present_q;

	rspr_pkg::cell_ctl_t       ctl;
	logic [DEPTH-1:0]          hits;
	logic [IDX_W-1:0]          match_idx;
	logic                      found;
	logic [rspr_pkg::ID_W-1:0] ent [DEPTH];
	logic                      rsp_free;

	// encode the single matching cell
	always_comb begin
		match_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (hits[i]) begin
				match_idx = match_idx | IDX_W'(i);
			end
		end
	end
	assign found = |hits;

	// broadcast control to the row
	always_comb begin
		ctl.cmp   = state_q == ST_CMP;
		ctl.add   = (state_q == ST_UPD) && (req_type_q == rspr_pkg::REQ_ADD);
		ctl.rmv   = (state_q == ST_UPD) && (req_type_q == rspr_pkg::REQ_REMOVE);
		ctl.found = found;
	end

	// cell row
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [rspr_pkg::ID_W-1:0] newer;
		logic [rspr_pkg::ID_W-1:0] older;

		if (g == 0) begin : g_head
			assign newer = id_q;
		end else begin : g_mid
			assign newer = ent[g-1];
		end
		if (g == DEPTH - 1) begin : g_tail
			assign older = ent[g];
		end else begin : g_body
			assign older = ent[g+1];
		end

		rspr_cell #(
			.DEPTH (DEPTH),
			.IDX   (g),
			.IDX_W (IDX_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.match_idx (match_idx),
			.count     (count_q),
			.id        (id_q),
			.newer     (newer),
			.older     (older),
			.entry     (ent[g]),
			.hit       (hits[g])
		);
	end

	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = state_q == ST_IDLE;

	// sequence one request through compare, shift and response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					found_q <= found;
					if (req_type_q == rspr_pkg::REQ_ADD) begin
						if (!found && (count_q != FULL)) begin
							count_q <= count_q + CNT_W'(1);
						end
					end else if (found) begin
						count_q <= count_q - CNT_W'(1);
					end
					state_q <= ST_RSP;
				end
				ST_RSP: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the request word
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_q <= req.req_type;
			id_q       <= req.window_id;
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_RSP) && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response word
	always_ff @(posedge clk) begin
		if ((state_q == ST_RSP) && rsp_free) begin
			top_q       <= (count_q != '0) ? ent[0] : '0;
			rsp_count_q <= count_q;
			empty_q     <= count_q == '0;
			present_q   <= found_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.top_window    = top_q;
	assign rsp.entry_count   = rsp_count_q;
	assign rsp.history_empty = empty_q;
	assign rsp.was_present   = present_q;

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for recency_stack_promote_remove
// Drives add and remove requests through the request channel and checks
// every response word against a behavioral copy of the recency history.
// A short directed table covers empty, full, promote and absent-remove
// cases. A long random run follows, biased between filling and draining.
// The request side sends in bursts and the response side stalls in
// patterns, with one long response hold and one full drain pause.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH  = rspr_pkg::DEPTH_DEF;
	localparam int RANDOM_WORDS = 1350;
	localparam int POOL_SIZE    = 20;
	localparam int DRAIN_AT     = 700;
	localparam int HOLD_AFTER   = 300;
	localparam int HOLD_CYCLES  = 400;

	// one response word as the stack reports it
	typedef struct packed {
		logic [rspr_pkg::ID_W-1:0] top;
		logic [4:0]                count;
		logic                      empty;
		logic                      present;
	} stack_status_t;

	// one directed request, with a hand-written expectation where typed is set
	typedef struct {
		logic          op;
		logic [31:0]   id;
		bit            typed;
		stack_status_t want;
	} directed_row_t;

	logic clk;
	logic arst_n;

	rspr_req_if req_ch ();
	rspr_rsp_if rsp_ch ();

	recency_stack_promote_remove #(
		.DEPTH (STACK_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// history model, index 0 oldest
	logic [rspr_pkg::ID_W-1:0] held_ids[$];
	stack_status_t             pending_status[$];
	directed_row_t             directed_rows[$];
	logic [rspr_pkg::ID_W-1:0] id_pool[POOL_SIZE];
	int                        errors;
	int                        delivered;
	int                        burst_left;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#(5_000_000);
		$display("status: fail");
		$finish;
	end

	// apply one request to the history model and return the status it yields
	function automatic stack_status_t apply_request(logic op,
			logic [rspr_pkg::ID_W-1:0] id);
		stack_status_t st;
		int            k;
		bit            hit;
		hit = 1'b0;
		// drop the newest copy of the identifier
		for (k = held_ids.size() - 1; k >= 0 && !hit; k--) begin
			if (held_ids[k] == id) begin
				held_ids.delete(k);
				hit = 1'b1;
			end
		end
		// push on top, evicting the oldest when full
		if (op == rspr_pkg::REQ_ADD) begin
			if (held_ids.size() >= STACK_DEPTH)
				void'(held_ids.pop_front());
			held_ids.push_back(id);
		end
		st.top     = (held_ids.size() != 0) ? held_ids[$] : '0;
		st.count   = 5'(held_ids.size());
		st.empty   = (held_ids.size() == 0);
		st.present = hit;
		return st;
	endfunction

	function automatic void put_row(logic op, logic [31:0] id, bit typed = 1'b0,
			logic [31:0] top = '0, logic [4:0] cnt = '0, logic emp = 1'b0,
			logic pres = 1'b0);
		directed_row_t r;
		r.op           = op;
		r.id           = id;
		r.typed        = typed;
		r.want.top     = top;
		r.want.count   = cnt;
		r.want.empty   = emp;
		r.want.present = pres;
		directed_rows.push_back(r);
	endfunction

	// offer one request word, with a random gap at each burst boundary,
	// then record the expected response once it is taken
	task automatic send_word(logic op, logic [rspr_pkg::ID_W-1:0] id, bit typed,
			stack_status_t want);
		int            gap;
		stack_status_t st;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= op;
		req_ch.window_id <= id;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		burst_left--;
		st = apply_request(op, id);
		pending_status.push_back(typed ? want : st);
	endtask

	// stimulus
	initial begin : stimulus
		int                        n;
		int                        add_pct;
		logic                      op;
		logic [rspr_pkg::ID_W-1:0] id;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = rspr_pkg::REQ_ADD;
		req_ch.window_id = '0;
		arst_n           = 1'b0;
		errors           = 0;
		burst_left       = 0;
		add_pct          = 50;

		// empty history, identifier extremes, promote and remove
		put_row(rspr_pkg::REQ_REMOVE, 32'd5, 1'b1, 32'd0, 5'd0, 1'b1, 1'b0);
		put_row(rspr_pkg::REQ_ADD, 32'd0, 1'b1, 32'd0, 5'd1, 1'b0, 1'b0);
		put_row(rspr_pkg::REQ_ADD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 5'd2, 1'b0, 1'b0);
		put_row(rspr_pkg::REQ_ADD, 32'd0, 1'b1, 32'd0, 5'd2, 1'b0, 1'b1);
		put_row(rspr_pkg::REQ_REMOVE, 32'd0, 1'b1, 32'hFFFF_FFFF, 5'd1, 1'b0, 1'b1);
		// fill up to the full depth
		for (n = 1; n < STACK_DEPTH; n++)
			put_row(rspr_pkg::REQ_ADD, n);
		// add when full evicts the oldest; promote the oldest while full
		put_row(rspr_pkg::REQ_ADD, 32'd16, 1'b1, 32'd16, 5'd16, 1'b0, 1'b0);
		put_row(rspr_pkg::REQ_ADD, 32'd1, 1'b1, 32'd1, 5'd16, 1'b0, 1'b1);
		// remove of an absent identifier, of the top and of a middle entry
		put_row(rspr_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 1'b1, 32'd1, 5'd16, 1'b0, 1'b0);
		put_row(rspr_pkg::REQ_REMOVE, 32'd1, 1'b1, 32'd16, 5'd15, 1'b0, 1'b1);
		put_row(rspr_pkg::REQ_REMOVE, 32'd8, 1'b1, 32'd16, 5'd14, 1'b0, 1'b1);

		// a small identifier pool makes hits and promotes common
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (n = 2; n < POOL_SIZE; n++)
			id_pool[n] = $urandom;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].op, directed_rows[i].id, directed_rows[i].typed,
				directed_rows[i].want);

		for (n = 0; n < RANDOM_WORDS; n++) begin
			// switch between filling, mixed and draining phases
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: add_pct = 85;
					1: add_pct = 50;
					default: add_pct = 15;
				endcase
			end
			// hold off until the block has answered everything
			if (n == DRAIN_AT) begin
				req_ch.valid <= 1'b0;
				burst_left = 0;
				do @(posedge clk); while (pending_status.size() != 0);
			end
			op = ($urandom_range(0, 99) < add_pct) ? rspr_pkg::REQ_ADD : rspr_pkg::REQ_REMOVE;
			id = ($urandom_range(0, 7) == 0) ? $urandom : id_pool[$urandom_range(0, POOL_SIZE - 1)];
			send_word(op, id, 1'b0, '0);
		end
		req_ch.valid <= 1'b0;

		// drain and let the pipeline settle
		while (pending_status.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// response side: stall patterns in segments, plus one long hold
	initial begin : response_side
		int seg_left;
		int seg_mode;
		int hold_left;
		bit hold_done;
		rsp_ch.ready = 1'b0;
		seg_left     = 0;
		seg_mode     = 0;
		hold_left    = 0;
		hold_done    = 1'b0;
		@(posedge arst_n);
		forever begin
			if (seg_left == 0) begin
				seg_mode = $urandom_range(0, 2);
				seg_left = $urandom_range(10, 60);
			end
			seg_left--;
			@(posedge clk);
			if (!hold_done && delivered >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (seg_mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// compare each response word with the oldest expectation
	initial delivered = 0;
	always @(posedge clk) begin : status_check
		stack_status_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			delivered++;
			if (pending_status.size() == 0) begin
				$display("%0t: unexpected word top=%h count=%0d empty=%b present=%b", $time,
					rsp_ch.top_window, rsp_ch.entry_count, rsp_ch.history_empty,
					rsp_ch.was_present);
				errors++;
			end else begin
				want = pending_status.pop_front();
				if (rsp_ch.top_window !== want.top) begin
					$display("%0t: top_window expected %h got %h", $time, want.top,
						rsp_ch.top_window);
					errors++;
				end
				if (rsp_ch.entry_count !== want.count) begin
					$display("%0t: entry_count expected %0d got %0d", $time, want.count,
						rsp_ch.entry_count);
					errors++;
				end
				if (rsp_ch.history_empty !== want.empty) begin
					$display("%0t: history_empty expected %b got %b", $time, want.empty,
						rsp_ch.history_empty);
					errors++;
				end
				if (rsp_ch.was_present !== want.present) begin
					$display("%0t: was_present expected %b got %b", $time, want.present,
						rsp_ch.was_present);
					errors++;
				end
			end
		end
	end

endmodule
